// ----- design/hsl_to_rgb_converter_core_assert.svh -----
// Assertion shorthands shared by the converter RTL.
// Both expect clk and rst_n to be visible where they are used.
`ifndef HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define HSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hsl2rgb_pkg.sv -----
package hsl2rgb_pkg;

    localparam int NUM_STAGES = 6;

    // Stage indexes along the pipe
    localparam int STG_WRAP = 0;
    localparam int STG_SEG  = 1;
    localparam int STG_DIFF = 2;
    localparam int STG_MUL  = 3;
    localparam int STG_SUM  = 4;
    localparam int STG_OUT  = 5;

    localparam int CHAN_W = 8;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Per-stage load strobes from the valid chain
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

    // Piece of the hue ramp a channel falls in
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } ramp_seg_t;

endpackage

// ----- design/hsl2rgb_if.sv -----
interface hsl2rgb_in_if #(parameter int IN_W = 17) ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] saturation;
    logic [IN_W-1:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface hsl2rgb_out_if import hsl2rgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

// ----- design/hsl2rgb_channel.sv -----
module hsl2rgb_channel import hsl2rgb_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                             clk,
    input  stage_ctl_t                       ctl,
    input  logic signed [FRACTION_BITS+2:0]  t,
    input  logic signed [FRACTION_BITS+5:0]  d,
    input  logic signed [FRACTION_BITS+5:0]  p,
    input  logic signed [FRACTION_BITS+5:0]  q,
    output logic [CHAN_W-1:0]                chan
);

    localparam int F   = FRACTION_BITS;
    localparam int TW  = F + 3;
    localparam int TXW = TW + 3;
    localparam int VW  = F + 6;
    localparam int MW  = F + 2;
    localparam int PW  = VW + MW + 1;
    localparam int VVW = F + 7;
    localparam int CW  = VVW + 8;

    localparam int ONE_I = 1 << F;
    localparam logic signed [TW-1:0]  SIXTH_T = TW'((ONE_I + 3) / 6);
    localparam logic signed [TW-1:0]  HALF_T  = TW'(ONE_I / 2);
    localparam logic signed [TW-1:0]  TT_T    = TW'((2 * ONE_I + 1) / 3);
    localparam logic signed [TXW-1:0] TT_X    = TXW'((2 * ONE_I + 1) / 3);

    ramp_seg_t               seg2_reg, seg2_next, seg3_reg, seg4_reg;
    logic [MW-1:0]           m2_reg, m2_next, m3_reg;
    logic signed [TXW-1:0]   t_x, diff_x, m_wide;
    logic signed [PW-1:0]    d_x, m_x, prod4_reg, prod4_next;
    logic signed [VVW-1:0]   v5_reg, v5_next;
    logic signed [CW-1:0]    scaled, floored;
    logic [CHAN_W-1:0]       chan6_reg, chan6_next;

    // Segment select and ramp slope (6t or 6(2/3 - t))
    always_comb
    begin
        t_x    = {{3{t[TW-1]}}, t};
        diff_x = TT_X - t_x;
        m_wide = '0;
        priority if (t < SIXTH_T)
        begin
            seg2_next = SEG_RISE;
            m_wide    = (t_x <<< 2) + (t_x <<< 1);
        end
        else if (t < HALF_T)
        begin
            seg2_next = SEG_HIGH;
        end
        else if (t < TT_T)
        begin
            seg2_next = SEG_FALL;
            m_wide    = (diff_x <<< 2) + (diff_x <<< 1);
        end
        else
        begin
            seg2_next = SEG_LOW;
        end
        m2_next = m_wide[MW-1:0];
    end

    // (q - p) * slope
    always_comb
    begin
        d_x        = PW'(d);
        m_x        = $signed(PW'(m3_reg));
        prod4_next = d_x * m_x;
    end

    always_comb
    begin
        unique case (seg4_reg)
            SEG_RISE, SEG_FALL: v5_next = VVW'(p) + VVW'(prod4_reg >>> F);
            SEG_HIGH:           v5_next = VVW'(q);
            SEG_LOW:            v5_next = VVW'(p);
            default:            v5_next = VVW'(p);
        endcase
    end

    // floor(v * 255), clamped to a byte
    always_comb
    begin
        scaled  = (CW'(v5_reg) <<< 8) - CW'(v5_reg);
        floored = scaled >>> F;
        if (floored[CW-1])
            chan6_next = '0;
        else if (|floored[CW-1:CHAN_W])
            chan6_next = CHAN_MAX;
        else
            chan6_next = floored[CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_SEG])
        begin
            seg2_reg <= seg2_next;
            m2_reg   <= m2_next;
        end
        if (ctl.load[STG_DIFF])
        begin
            seg3_reg <= seg2_reg;
            m3_reg   <= m2_reg;
        end
        if (ctl.load[STG_MUL])
        begin
            seg4_reg  <= seg3_reg;
            prod4_reg <= prod4_next;
        end
        if (ctl.load[STG_SUM])
            v5_reg <= v5_next;
        if (ctl.load[STG_OUT])
            chan6_reg <= chan6_next;
    end

    assign chan = chan6_reg;

endmodule

// ----- design/hsl_to_rgb_converter_core.sv -----
// HSL to RGB pixel converter.
//
// pixel_in carries hue, saturation and lightness as unsigned fractions with
// FRACTION_BITS fractional bits (2^FRACTION_BITS is 1.0, one extra integer
// bit). pixel_out carries 8-bit red, green and blue. Both channels use
// valid/ready; a request moves when valid and ready are high at a clock edge.
//
// A result passes through six register stages before it shows on pixel_out:
// hue wrap and lightness multiply, q/p, q-p, ramp multiply, ramp sum, byte
// scaling. Throughput is one pixel per cycle while pixel_out does not stall.
//
// Each stage has its own valid bit and advances when empty or when the stage
// after it advances. A stall on pixel_out holds the full stages in place;
// empty stages upstream keep taking requests until the pipe is full.
// Asynchronous reset empties the pipe; payload registers are not reset.
`include "hsl_to_rgb_converter_core_assert.svh"

module hsl_to_rgb_converter_core import hsl2rgb_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    hsl2rgb_in_if.sink    pixel_in,
    hsl2rgb_out_if.source pixel_out
);

    localparam int F     = FRACTION_BITS;
    localparam int IN_W  = F + 1;
    localparam int TW    = F + 3;
    localparam int VW    = F + 6;
    localparam int MB_W  = F + 2;
    localparam int P1_W  = IN_W + MB_W;
    localparam int LAST  = NUM_STAGES - 1;
    localparam int ONE_I = 1 << F;

    localparam logic [MB_W-1:0]      ONE_M   = MB_W'(ONE_I);
    localparam logic [IN_W-1:0]      HALF_L  = IN_W'(ONE_I / 2);
    localparam logic signed [TW-1:0] ONE_T   = TW'(ONE_I);
    localparam logic signed [TW-1:0] THIRD_T = TW'((ONE_I + 1) / 3);

    // Valid chain
    logic [NUM_STAGES-1:0] vld_reg, vld_next, adv;
    stage_ctl_t            ctl;

    // Stage 1: lightness product and wrapped hues
    logic [MB_W-1:0]        mb;
    logic [P1_W-1:0]        prod1_reg, prod1_next;
    logic [IN_W-1:0]        l1_reg, s1_reg;
    logic                   low1_reg;
    logic signed [TW-1:0]   h_ext;
    logic signed [TW-1:0]   t1_next [3];
    logic signed [TW-1:0]   t1_reg  [3];

    // Stages 2..4: q, p and their difference
    logic signed [VW-1:0]   q2_reg, q2_next, p2_reg, p2_next;
    logic signed [VW-1:0]   fl_ls;
    logic signed [VW-1:0]   d3_reg, p3_reg, q3_reg, p4_reg, q4_reg;

    logic [CHAN_W-1:0]      chan [3];

    logic in_acc, out_acc;

    function automatic logic signed [TW-1:0] wrap_hue(input logic signed [TW-1:0] t_in);
        logic signed [TW-1:0] tw;
        tw = t_in;
        if (tw < 0)
            tw = tw + ONE_T;
        if (tw > ONE_T)
            tw = tw - ONE_T;
        return tw;
    endfunction

    // ---------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its successor loads.
    // ---------------------------------------------------------------------
    always_comb
    begin
        adv[LAST] = !vld_reg[LAST] || pixel_out.ready;
        for (int k = LAST - 1; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
            vld_next[0] = pixel_in.valid;
        for (int k = 1; k < NUM_STAGES; k++)
            if (adv[k])
                vld_next[k] = vld_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign ctl.load       = adv;
    assign pixel_in.ready = adv[0];

    // ---------------------------------------------------------------------
    // Stage 1. Below one half, q = l * (1 + s); otherwise q = l + s - l * s.
    // Either way one product of lightness is needed.
    // ---------------------------------------------------------------------
    always_comb
    begin
        mb = (pixel_in.lightness < HALF_L) ? ONE_M + MB_W'(pixel_in.saturation)
                                           : MB_W'(pixel_in.saturation);
        prod1_next = P1_W'(pixel_in.lightness) * P1_W'(mb);
        h_ext      = $signed(TW'(pixel_in.hue));
        t1_next[0] = wrap_hue(h_ext + THIRD_T);   // red
        t1_next[1] = wrap_hue(h_ext);             // green
        t1_next[2] = wrap_hue(h_ext - THIRD_T);   // blue
    end

    // ---------------------------------------------------------------------
    // Stage 2: q and p = 2l - q. Zero saturation falls out as q = p = l,
    // which makes every channel grey without a special path.
    // ---------------------------------------------------------------------
    always_comb
    begin
        fl_ls = $signed(VW'(prod1_reg >> F));
        if (low1_reg)
            q2_next = fl_ls;
        else
            q2_next = $signed(VW'(l1_reg)) + $signed(VW'(s1_reg)) - fl_ls;
        p2_next = $signed(VW'({l1_reg, 1'b0})) - q2_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv[STG_WRAP])
        begin
            prod1_reg <= prod1_next;
            l1_reg    <= pixel_in.lightness;
            s1_reg    <= pixel_in.saturation;
            low1_reg  <= (pixel_in.lightness < HALF_L);
            t1_reg    <= t1_next;
        end
        if (adv[STG_SEG])
        begin
            q2_reg <= q2_next;
            p2_reg <= p2_next;
        end
        if (adv[STG_DIFF])
        begin
            d3_reg <= q2_reg - p2_reg;
            p3_reg <= p2_reg;
            q3_reg <= q2_reg;
        end
        if (adv[STG_MUL])
        begin
            p4_reg <= p3_reg;
            q4_reg <= q3_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Per-channel ramp, product, sum and byte scaling (stages 2..6)
    // ---------------------------------------------------------------------
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        hsl2rgb_channel #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_chan (
            .clk  (clk),
            .ctl  (ctl),
            .t    (t1_reg[c]),
            .d    (d3_reg),
            .p    (p4_reg),
            .q    (q4_reg),
            .chan (chan[c])
        );
    end

    assign pixel_out.valid = vld_reg[LAST];
    assign pixel_out.red   = chan[0];
    assign pixel_out.green = chan[1];
    assign pixel_out.blue  = chan[2];

    // ---------------------------------------------------------------------
    // Checks: occupancy moves only with requests in and out, and a bubble
    // anywhere in the pipe must open the input.
    // ---------------------------------------------------------------------
    assign in_acc  = pixel_in.valid && adv[0];
    assign out_acc = vld_reg[LAST] && pixel_out.ready;

    `HSL_ASSERT_NOW(a_bubble_ready, !(&vld_reg), pixel_in.ready,
        "pipe has a bubble but input is stalled")
    `HSL_ASSERT_NEXT(a_fill_count, in_acc && !out_acc,
        $countones(vld_reg) == $past($countones(vld_reg)) + 1,
        "occupancy did not grow on accepted request")
    `HSL_ASSERT_NEXT(a_drain_count, out_acc && !in_acc,
        $countones(vld_reg) + 1 == $past($countones(vld_reg)),
        "occupancy did not shrink on delivered result")
    `HSL_ASSERT_NEXT(a_hold_count, in_acc == out_acc,
        $countones(vld_reg) == $past($countones(vld_reg)),
        "occupancy changed without net traffic")

endmodule
